FILE: hw/rtl/bvu_pkg.sv
// ----------------------------------------------------------------------------
// bvu_pkg
// Shared types, constants and helper functions for the buoyancy velocity
// update pipeline.
// ----------------------------------------------------------------------------
package bvu_pkg;

   localparam logic [29:0] HALF_FLOOR  = 30'd1311;
   localparam logic [30:0] DENS_FLOOR  = 31'd3277;
   localparam logic [18:0] MAX_GB      = 19'd393216;
   localparam logic [16:0] LOG2E_Q16   = 17'd94548;
   localparam logic [16:0] FRAC_ONE    = 17'd65536;
   localparam logic [30:0] GRAVITY_RST = 31'd642908;
   localparam logic [30:0] TSTEP_RST   = 31'd1092;

   localparam logic [1:0] REG_GRAVITY   = 2'd0;
   localparam logic [1:0] REG_TIME_STEP = 2'd1;

   typedef struct packed {
      logic [30:0] gravity;
      logic [30:0] time_step;
   } cfg_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [20:0] quo;
   } div_type;

   typedef struct packed {
      logic [5:0][31:0] vel;
      logic [31:0]      water;
      logic [31:0]      body_y;
      logic [30:0]      bheight;
      logic [30:0]      dens;
      logic [30:0]      drag;
      logic [30:0]      adrag;
      logic             on;
      logic             full;
      logic             cap;
      logic [31:0]      rem;
      logic [30:0]      den;
      logic [20:0]      quo;
      logic [16:0]      frac;
      logic [33:0]      acc;
      logic [48:0]      lift_hi;
      logic [49:0]      lift_lo;
      logic [31:0]      xl1;
      logic [31:0]      xa1;
      logic [46:0]      xl;
      logic [46:0]      xa;
      logic [21:0]      yl;
      logic [21:0]      ya;
      logic             bigl;
      logic             biga;
      logic [16:0]      rl;
      logic [16:0]      ra;
      logic [5:0][48:0] prod;
   } pipe_type;

   // one restoring division step: shift in a bit, subtract if it fits
   function automatic div_type div_step(input logic [31:0] rem, input logic [30:0] den,
                                        input logic [20:0] quo, input logic bit_in);
      logic [31:0] sh;
      logic        ge;
      div_type     res;
      sh = {rem[30:0], bit_in};
      ge = (sh >= {1'b0, den});
      res.rem = ge ? (sh - {1'b0, den}) : sh;
      res.quo = {quo[19:0], ge};
      return res;
   endfunction

   function automatic logic [63:0] isqrt(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bt;
      v = v_arg;
      res = 64'd0;
      bt = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bt) begin
            v = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // 2^(-k/2^bits) in Q1.30
   function automatic logic [30:0] exp_entry(input int bits, input int k);
      logic [63:0] roots [13];
      logic [63:0] acc;
      for (int j = 0; j < 13; j++) begin
         roots[j] = 64'd0;
      end
      roots[0] = 64'd536870912;
      for (int j = 1; j < 13; j++) begin
         if (j <= bits) begin
            roots[j] = isqrt(roots[j-1] << 30);
         end
      end
      acc = 64'd1073741824;
      for (int j = 0; j < 12; j++) begin
         if (j < bits && ((k >> j) & 1) == 1) begin
            acc = (acc * roots[bits-j]) >> 30;
         end
      end
      return acc[30:0];
   endfunction

endpackage

FILE: hw/rtl/buoyancy_velocity_update_core.sv
// ----------------------------------------------------------------------------
// buoyancy_velocity_update_core
// Buoyancy and water drag velocity update, one body per word.
// ----------------------------------------------------------------------------
// Takes one body word per clock unless stalled and returns one result word per
// body, in order, after the fraction divider, density divider, lift products
// and drag decay. The pipeline advances as a whole: a stall on the result side
// holds every stage and is passed back to the request side in the same cycle.
// Gravity and time step are written through the csr port; the user must do so
// only while no body is in flight, as the core does not enforce it.
// ----------------------------------------------------------------------------
module buoyancy_velocity_update_core
   import bvu_pkg::*;
#(
   parameter int EXP_TABLE_BITS = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_water_level,
   input  logic [31:0] req_body_y,
   input  logic [30:0] req_body_height,
   input  logic [30:0] req_density,
   input  logic [30:0] req_drag,
   input  logic [30:0] req_angular_drag,
   input  logic [31:0] req_vel_x,
   input  logic [31:0] req_vel_y,
   input  logic [31:0] req_vel_z,
   input  logic [31:0] req_spin_x,
   input  logic [31:0] req_spin_y,
   input  logic [31:0] req_spin_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_new_vel_x,
   output logic [31:0] rsp_new_vel_y,
   output logic [31:0] rsp_new_vel_z,
   output logic [31:0] rsp_new_spin_x,
   output logic [31:0] rsp_new_spin_y,
   output logic [31:0] rsp_new_spin_z,
   output logic [16:0] rsp_submerged_fraction,
   output logic        rsp_applied,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     en;
   pipe_type in_dat;
   logic     a_valid, b_valid, c_valid;
   pipe_type a_dat, b_dat, c_dat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity   <= GRAVITY_RST;
         cfg_ff.time_step <= TSTEP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GRAVITY:   cfg_ff.gravity   <= csr_wdata[30:0];
            REG_TIME_STEP: cfg_ff.time_step <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // hold every stage while the result word waits
   assign en        = !(c_valid && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      in_dat = '0;
      in_dat.water   = req_water_level;
      in_dat.body_y  = req_body_y;
      in_dat.bheight = req_body_height;
      in_dat.dens    = req_density;
      in_dat.drag    = req_drag;
      in_dat.adrag   = req_angular_drag;
      in_dat.vel[0]  = req_vel_x;
      in_dat.vel[1]  = req_vel_y;
      in_dat.vel[2]  = req_vel_z;
      in_dat.vel[3]  = req_spin_x;
      in_dat.vel[4]  = req_spin_y;
      in_dat.vel[5]  = req_spin_z;
   end

   bvu_frac u_frac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_dat    (in_dat),
      .out_valid (a_valid),
      .out_dat   (a_dat)
   );

   bvu_lift u_lift (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (a_valid),
      .in_dat    (a_dat),
      .out_valid (b_valid),
      .out_dat   (b_dat)
   );

   bvu_decay #(
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_decay (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (b_valid),
      .in_dat    (b_dat),
      .out_valid (c_valid),
      .out_dat   (c_dat)
   );

   assign rsp_valid              = c_valid;
   assign rsp_new_vel_x          = c_dat.vel[0];
   assign rsp_new_vel_y          = c_dat.vel[1];
   assign rsp_new_vel_z          = c_dat.vel[2];
   assign rsp_new_spin_x         = c_dat.vel[3];
   assign rsp_new_spin_y         = c_dat.vel[4];
   assign rsp_new_spin_z         = c_dat.vel[5];
   assign rsp_submerged_fraction = c_dat.frac;
   assign rsp_applied            = c_dat.on;

endmodule

FILE: hw/rtl/bvu_frac.sv
// ----------------------------------------------------------------------------
// bvu_frac
// Submerged fraction: extent floor, numerator, and a 16 stage restoring
// divider for num * 2^16 / (2 * half).
// ----------------------------------------------------------------------------
module bvu_frac
   import bvu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cfg_type  cfg,
   input  logic     in_valid,
   input  pipe_type in_dat,
   output logic     out_valid,
   output pipe_type out_dat
);

   localparam int STEPS = 16;

   logic     v_ff [STEPS+1];
   pipe_type d_ff [STEPS+1];
   pipe_type d0_in;

   logic [29:0] half;
   logic [33:0] num;

   always_comb begin
      d0_in = in_dat;
      half = (in_dat.bheight[30:1] < HALF_FLOOR) ? HALF_FLOOR : in_dat.bheight[30:1];
      num = {{2{in_dat.water[31]}}, in_dat.water} - {{2{in_dat.body_y[31]}}, in_dat.body_y}
            + {4'b0, half};
      d0_in.den = {half, 1'b0};
      d0_in.on = (cfg.gravity != 31'd0) && (cfg.time_step != 31'd0) && !num[33]
                 && (num != 34'd0);
      d0_in.full = (num[32:0] >= {2'b0, half, 1'b0});
      d0_in.rem = num[31:0];
      d0_in.quo = 21'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         d_ff[0] <= d0_in;
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      pipe_type s_in;
      div_type  dv;
      always_comb begin
         s_in = d_ff[s-1];
         dv = div_step(d_ff[s-1].rem, d_ff[s-1].den, d_ff[s-1].quo, 1'b0);
         s_in.rem = dv.rem;
         s_in.quo = dv.quo;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_ff[s-1];
         end
         if (en) begin
            d_ff[s] <= s_in;
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_dat   = d_ff[STEPS];

endmodule

FILE: hw/rtl/bvu_lift.sv
// ----------------------------------------------------------------------------
// bvu_lift
// Buoyant lift: density floor, 19 stage divider for fraction / density,
// gravity and time step products, saturating add to the vertical velocity.
// ----------------------------------------------------------------------------
module bvu_lift
   import bvu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cfg_type  cfg,
   input  logic     in_valid,
   input  pipe_type in_dat,
   output logic     out_valid,
   output pipe_type out_dat
);

   localparam int STEPS = 19;
   localparam int LAST  = STEPS + 3;

   logic     v_ff [LAST+1];
   pipe_type d_ff [LAST+1];
   pipe_type d0_in;
   pipe_type m1_in;
   pipe_type m2_in;
   pipe_type m3_in;

   logic [16:0] frac;
   logic [30:0] dens;
   logic [33:0] dens6;
   logic [18:0] gb;
   logic [49:0] gprod;
   logic [50:0] lift;
   logic [52:0] vsum;

   always_comb begin
      d0_in = in_dat;
      frac = in_dat.full ? FRAC_ONE : {1'b0, in_dat.quo[15:0]};
      dens = (in_dat.dens < DENS_FLOOR) ? DENS_FLOOR : in_dat.dens;
      dens6 = {1'b0, dens, 2'b0} + {2'b0, dens, 1'b0};
      d0_in.frac = frac;
      d0_in.on = in_dat.on && (frac != 17'd0);
      d0_in.dens = dens;
      d0_in.den = dens;
      d0_in.cap = ({17'b0, frac} >= dens6);
      // quotient stays below 2^19 once the cap is ruled out
      d0_in.rem = {18'b0, frac[16:3]};
      d0_in.quo = 21'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         d_ff[0] <= d0_in;
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      pipe_type s_in;
      div_type  dv;
      logic     bit_in;
      always_comb begin
         s_in = d_ff[s-1];
         bit_in = (s <= 3) ? d_ff[s-1].frac[(s <= 3) ? (3 - s) : 0] : 1'b0;
         dv = div_step(d_ff[s-1].rem, d_ff[s-1].den, d_ff[s-1].quo, bit_in);
         s_in.rem = dv.rem;
         s_in.quo = dv.quo;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_ff[s-1];
         end
         if (en) begin
            d_ff[s] <= s_in;
         end
      end
   end

   always_comb begin
      m1_in = d_ff[STEPS];
      gb = d_ff[STEPS].cap ? MAX_GB : d_ff[STEPS].quo[18:0];
      gprod = cfg.gravity * gb;
      m1_in.acc = gprod[49:16];
   end

   always_comb begin
      m2_in = d_ff[STEPS+1];
      m2_in.lift_hi = d_ff[STEPS+1].acc * cfg.time_step[30:16];
      m2_in.lift_lo = d_ff[STEPS+1].acc * cfg.time_step[15:0];
   end

   always_comb begin
      m3_in = d_ff[STEPS+2];
      lift = {2'b0, d_ff[STEPS+2].lift_hi} + {17'b0, d_ff[STEPS+2].lift_lo[49:16]};
      vsum = {{21{d_ff[STEPS+2].vel[1][31]}}, d_ff[STEPS+2].vel[1]} + {2'b0, lift};
      if (d_ff[STEPS+2].on) begin
         if (vsum[52:31] == {22{vsum[52]}}) begin
            m3_in.vel[1] = vsum[31:0];
         end else begin
            m3_in.vel[1] = vsum[52] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[STEPS+1] <= 1'b0;
         v_ff[STEPS+2] <= 1'b0;
         v_ff[STEPS+3] <= 1'b0;
      end else if (en) begin
         v_ff[STEPS+1] <= v_ff[STEPS];
         v_ff[STEPS+2] <= v_ff[STEPS+1];
         v_ff[STEPS+3] <= v_ff[STEPS+2];
      end
      if (en) begin
         d_ff[STEPS+1] <= m1_in;
         d_ff[STEPS+2] <= m2_in;
         d_ff[STEPS+3] <= m3_in;
      end
   end

   assign out_valid = v_ff[LAST];
   assign out_dat   = d_ff[LAST];

endmodule

FILE: hw/rtl/bvu_decay.sv
// ----------------------------------------------------------------------------
// bvu_decay
// Drag decay: exponent products, base-2 table lookup, and scaling of the
// six velocity components toward zero.
// ----------------------------------------------------------------------------
module bvu_decay
   import bvu_pkg::*;
#(
   parameter int EXP_TABLE_BITS = 8
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cfg_type  cfg,
   input  logic     in_valid,
   input  pipe_type in_dat,
   output logic     out_valid,
   output pipe_type out_dat
);

   localparam int DEPTH = 1 << EXP_TABLE_BITS;
   localparam int NSTG  = 6;

   logic [30:0] tbl [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_tbl
      assign tbl[k] = exp_entry(EXP_TABLE_BITS, k);
   end

   logic     v_ff [NSTG];
   pipe_type d_ff [NSTG];
   pipe_type s_in [NSTG];

   logic [47:0] pl1, pa1;
   logic [62:0] pl2, pa2;
   logic [37:0] pl3, pa3;
   logic [4:0]  shl, sha;
   logic [30:0] tl, ta;
   logic [5:0][31:0] mag;
   logic [5:0][31:0] mres;

   always_comb begin
      s_in[0] = in_dat;
      pl1 = in_dat.drag * in_dat.frac;
      pa1 = in_dat.adrag * in_dat.frac;
      s_in[0].xl1 = pl1[47:16];
      s_in[0].xa1 = pa1[47:16];

      s_in[1] = d_ff[0];
      pl2 = d_ff[0].xl1 * cfg.time_step;
      pa2 = d_ff[0].xa1 * cfg.time_step;
      s_in[1].xl = pl2[62:16];
      s_in[1].xa = pa2[62:16];

      // exponents of 2^21 and above always land past the table range
      s_in[2] = d_ff[1];
      pl3 = d_ff[1].xl[20:0] * LOG2E_Q16;
      pa3 = d_ff[1].xa[20:0] * LOG2E_Q16;
      s_in[2].yl = pl3[37:16];
      s_in[2].ya = pa3[37:16];
      s_in[2].bigl = (d_ff[1].xl[46:21] != 26'd0);
      s_in[2].biga = (d_ff[1].xa[46:21] != 26'd0);

      s_in[3] = d_ff[2];
      tl = tbl[d_ff[2].yl[15 -: EXP_TABLE_BITS]];
      ta = tbl[d_ff[2].ya[15 -: EXP_TABLE_BITS]];
      shl = 5'd14 + d_ff[2].yl[20:16];
      sha = 5'd14 + d_ff[2].ya[20:16];
      s_in[3].rl = (d_ff[2].bigl || d_ff[2].yl[21:16] > 6'd16) ? 17'd0 : 17'(tl >> shl);
      s_in[3].ra = (d_ff[2].biga || d_ff[2].ya[21:16] > 6'd16) ? 17'd0 : 17'(ta >> sha);

      s_in[4] = d_ff[3];
      for (int i = 0; i < 6; i++) begin
         mag[i] = d_ff[3].vel[i][31] ? (~d_ff[3].vel[i] + 32'd1) : d_ff[3].vel[i];
         s_in[4].prod[i] = mag[i] * ((i < 3) ? d_ff[3].rl : d_ff[3].ra);
      end

      // restore the sign; pass untouched words' velocities straight through and clear their fraction
      s_in[5] = d_ff[4];
      for (int i = 0; i < 6; i++) begin
         mres[i] = d_ff[4].prod[i][47:16];
         if (d_ff[4].on) begin
            s_in[5].vel[i] = d_ff[4].vel[i][31] ? (~mres[i] + 32'd1) : mres[i];
         end
      end
      if (!d_ff[4].on) begin
         s_in[5].frac = 17'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NSTG; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
      if (en) begin
         for (int i = 0; i < NSTG; i++) begin
            d_ff[i] <= s_in[i];
         end
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_dat   = d_ff[NSTG-1];

endmodule

FILE: hw/rtl/bvu_checker.sv
// ----------------------------------------------------------------------------
// bvu_checker
// Port-level checks for the buoyancy velocity update core.
// ----------------------------------------------------------------------------
module bvu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_submerged_fraction,
   input logic        rsp_applied
);

   a_out_of_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result word dropped");

   a_applied_frac: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_applied) |-> (rsp_submerged_fraction != 17'd0))
      else $error("applied word with zero fraction");

   a_passed_frac: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_applied) |-> (rsp_submerged_fraction == 17'd0))
      else $error("unchanged word with nonzero fraction");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_submerged_fraction <= 17'd65536))
      else $error("fraction above one");

endmodule

bind buoyancy_velocity_update_core bvu_checker u_checker (.*);
